// ===== rtl/core/lfuws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lfuws_pkg;

  // cache geometry
  localparam int WAYS    = 16;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W   = 32;
  localparam int COUNT_W = 32;
  localparam int WAYF_W  = 4;

  localparam logic [COUNT_W-1:0] COUNT_ALL_ONES = {COUNT_W{1'b1}};

  // transaction kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // update broadcast to every cell
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_INC   = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [WAY_W-1:0] idx;
    logic [TAG_W-1:0] tag;
    logic             halve;
  } cmd_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic               found;
    logic [WAY_W-1:0]   found_way;
    logic [COUNT_W-1:0] found_count;
    logic [COUNT_W-1:0] low_count;
    logic [WAY_W-1:0]   min_way;
  } tok_t;

  // low bits of a way number as carried in the result
  function automatic logic [WAYF_W-1:0] way_field(input logic [WAY_W-1:0] idx);
    logic [63:0] wide;
    wide = 64'(idx);
    return wide[WAYF_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lfuws_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lfuws_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [lfuws_pkg::TAG_W-1:0] table_tag;

  modport source (output valid, output kind, output table_tag, input ready);
  modport sink   (input valid, input kind, input table_tag, output ready);
endinterface

interface lfuws_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [lfuws_pkg::WAYF_W-1:0] way;

  modport source (output valid, output hit, output way, input ready);
  modport sink   (input valid, input hit, input way, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfuws_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfuws_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [lfuws_pkg::WAY_W-1:0] cell_idx,
  input  wire lfuws_pkg::cmd_t             cmd,
  input  wire lfuws_pkg::tok_t             tok_in,
  output lfuws_pkg::tok_t                  tok_out
);

  logic [lfuws_pkg::TAG_W-1:0]   tag_r, tag_nxt;
  logic [lfuws_pkg::COUNT_W-1:0] count_r, count_nxt;
  lfuws_pkg::tok_t               tok_r, tok_nxt;
  logic                          sel;
  logic                          match;

  // apply the broadcast update to this way
  always_comb begin
    tag_nxt   = tag_r;
    count_nxt = count_r;
    sel       = (cmd.idx == cell_idx);
    case (cmd.op)
      lfuws_pkg::OP_CLEAR: begin
        tag_nxt   = '0;
        count_nxt = '0;
      end
      lfuws_pkg::OP_INC: begin
        if (sel) begin
          count_nxt = count_r + lfuws_pkg::COUNT_W'(1);
        end
        if (cmd.halve) begin
          count_nxt = {1'b0, count_nxt[lfuws_pkg::COUNT_W-1:1]};
        end
      end
      lfuws_pkg::OP_WRITE: begin
        if (sel) begin
          tag_nxt   = cmd.tag;
          count_nxt = lfuws_pkg::COUNT_W'(1);
        end
      end
      default: begin
        tag_nxt   = tag_r;
        count_nxt = count_r;
      end
    endcase
  end

  // fold this way into the passing search token
  always_comb begin
    tok_nxt = tok_in;
    match   = (tag_r == tok_in.tag);
    if (!tok_in.found && match) begin
      tok_nxt.found       = 1'b1;
      tok_nxt.found_way   = cell_idx;
      tok_nxt.found_count = count_r;
    end
    if (count_r < tok_in.low_count) begin
      tok_nxt.low_count = count_r;
      tok_nxt.min_way   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= '0;
      count_r <= '0;
      tok_r   <= '0;
    end else begin
      tag_r   <= tag_nxt;
      count_r <= count_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// ===== rtl/core/lfu_table_cache_way_select_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Least-frequently-used tag cache of WAYS (16) fully associative ways for table pages.
// Each way is one cell in a chain; a lookup sends a search token down the chain, one cell
// per clock, which collects the first matching way and the lowest-count way. The commit
// state then updates the ways and loads the result register. A lookup goes from idle
// through search, while the token walks the cell chain, to commit; a flush goes straight
// to commit. One transaction is worked on at a time; the next can be accepted while the
// previous result still waits in the output register. No clearing pass after reset.

module lfu_table_cache_way_select_top (
  input  wire logic     clk,
  input  wire logic     rst_n,
  lfuws_in_if.sink      in_ch,
  lfuws_out_if.source   out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t                             state_r, state_nxt;
  lfuws_pkg::tok_t                    tok_chain [lfuws_pkg::WAYS+1];
  logic [lfuws_pkg::WAYS-1:0]         tok_valids;
  lfuws_pkg::cmd_t                    cmd;
  lfuws_pkg::tok_t                    tok_last;

  logic                               in_fire;
  logic                               commit_go;
  logic                               res_flush_r;
  logic                               res_found_r;
  logic [lfuws_pkg::WAY_W-1:0]        res_way_r;
  logic [lfuws_pkg::COUNT_W-1:0]      res_count_r;
  logic [lfuws_pkg::TAG_W-1:0]        res_tag_r;
  logic [lfuws_pkg::COUNT_W-1:0]      inc_count;

  logic                               out_valid_r, out_valid_nxt;
  logic                               out_hit_r;
  logic [lfuws_pkg::WAYF_W-1:0]       out_way_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign commit_go   = (state_r == ST_COMMIT) && (!out_valid_r || out_ch.ready);
  assign tok_last    = tok_chain[lfuws_pkg::WAYS];

  // launch a search token into the first cell
  always_comb begin
    tok_chain[0].valid       = in_fire && (in_ch.kind == lfuws_pkg::KIND_LOOKUP);
    tok_chain[0].tag         = in_ch.table_tag;
    tok_chain[0].found       = 1'b0;
    tok_chain[0].found_way   = '0;
    tok_chain[0].found_count = '0;
    tok_chain[0].low_count   = lfuws_pkg::COUNT_ALL_ONES;
    tok_chain[0].min_way     = '0;
  end

  // chain of way cells
  for (genvar i = 0; i < lfuws_pkg::WAYS; i++) begin : g_cell
    lfuws_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (lfuws_pkg::WAY_W'(i)),
      .cmd      (cmd),
      .tok_in   (tok_chain[i]),
      .tok_out  (tok_chain[i+1])
    );
    assign tok_valids[i] = tok_chain[i+1].valid;
  end

  // update command issued in the commit cycle
  always_comb begin
    inc_count = res_count_r + lfuws_pkg::COUNT_W'(1);
    cmd.op    = lfuws_pkg::OP_NONE;
    cmd.idx   = res_way_r;
    cmd.tag   = res_tag_r;
    cmd.halve = (inc_count == lfuws_pkg::COUNT_ALL_ONES);
    if (commit_go) begin
      if (res_flush_r) begin
        cmd.op = lfuws_pkg::OP_CLEAR;
      end else if (res_found_r) begin
        cmd.op = lfuws_pkg::OP_INC;
      end else begin
        cmd.op = lfuws_pkg::OP_WRITE;
      end
    end
  end

  // control sequence
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.kind == lfuws_pkg::KIND_FLUSH) ? ST_COMMIT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tok_last.valid) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // search result and transaction kind; the tag is held here since the
  // chain keeps shifting after the token has left it
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_flush_r <= (in_ch.kind == lfuws_pkg::KIND_FLUSH);
    end
    if (tok_last.valid) begin
      res_found_r <= tok_last.found;
      res_way_r   <= tok_last.found ? tok_last.found_way : tok_last.min_way;
      res_count_r <= tok_last.found_count;
      res_tag_r   <= tok_last.tag;
    end
  end

  // result register loaded at the commit
  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_hit_r <= !res_flush_r && res_found_r;
      out_way_r <= res_flush_r ? '0 : lfuws_pkg::way_field(res_way_r);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = out_hit_r;
  assign out_ch.way   = out_way_r;

  // at most one search token in the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valids))
    else $error("more than one search token in flight");

  // token leaves the chain only while searching
  a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.valid |-> (state_r == ST_SEARCH))
    else $error("search token left the chain outside a search");

  // every commit produces a result
  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit_go |=> out_valid_r)
    else $error("commit did not load the result register");

  // no update to the ways while a token is walking
  a_no_update_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_valids != '0) |-> (cmd.op == lfuws_pkg::OP_NONE))
    else $error("ways updated during a search");

endmodule

`default_nettype wire
